### rtl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg: shared types and constants for the AABB frustum cull test
// Operation codes, fixed field widths and the stage-advance bundle.
// ----------------------------------------------------------------------------
package afc_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TEST  = 1'b1
  } op_t;

  localparam int PLANE_IDX_W = 3;
  localparam int OUT_W       = 8;

  // advance strobes for the three plane-evaluation register stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } afc_stage_en_t;

endpackage

### rtl/afc_plane_table.sv
// ----------------------------------------------------------------------------
// afc_plane_table: frustum plane storage
// Holds NUM_PLANES planes (normal and offset), cleared to zero at reset.
// ----------------------------------------------------------------------------
module afc_plane_table import afc_pkg::*; #(
  parameter int NUM_PLANES  = 6,
  parameter int COORD_BITS  = 32,
  parameter int NORMAL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [PLANE_IDX_W-1:0]        wr_idx,
  input  logic signed [NORMAL_BITS-1:0] wr_nx,
  input  logic signed [NORMAL_BITS-1:0] wr_ny,
  input  logic signed [NORMAL_BITS-1:0] wr_nz,
  input  logic signed [COORD_BITS-1:0]  wr_off,
  output logic signed [NORMAL_BITS-1:0] nx  [NUM_PLANES],
  output logic signed [NORMAL_BITS-1:0] ny  [NUM_PLANES],
  output logic signed [NORMAL_BITS-1:0] nz  [NUM_PLANES],
  output logic signed [COORD_BITS-1:0]  off [NUM_PLANES]
);

  // an index at or above NUM_PLANES matches no entry, so the write is dropped
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      if (rst) begin
        nx[i]  <= '0;
        ny[i]  <= '0;
        nz[i]  <= '0;
        off[i] <= '0;
      end else if (wr_en && (wr_idx == PLANE_IDX_W'(i))) begin
        nx[i]  <= wr_nx;
        ny[i]  <= wr_ny;
        nz[i]  <= wr_nz;
        off[i] <= wr_off;
      end
    end
  end

endmodule

### rtl/afc_plane_eval.sv
// ----------------------------------------------------------------------------
// afc_plane_eval: signed distance of the positive vertex to one plane
// Three stages: vertex select, products, sum. Returns the distance sign.
// ----------------------------------------------------------------------------
module afc_plane_eval import afc_pkg::*; #(
  parameter int COORD_BITS  = 32,
  parameter int NORMAL_BITS = 16
) (
  input  logic                          clk,
  input  afc_stage_en_t                 en,
  input  logic signed [NORMAL_BITS-1:0] nx,
  input  logic signed [NORMAL_BITS-1:0] ny,
  input  logic signed [NORMAL_BITS-1:0] nz,
  input  logic signed [COORD_BITS-1:0]  off,
  input  logic signed [COORD_BITS-1:0]  min_x,
  input  logic signed [COORD_BITS-1:0]  min_y,
  input  logic signed [COORD_BITS-1:0]  min_z,
  input  logic signed [COORD_BITS-1:0]  max_x,
  input  logic signed [COORD_BITS-1:0]  max_y,
  input  logic signed [COORD_BITS-1:0]  max_z,
  output logic                          dist_neg
);

  localparam int FRAC_BITS = NORMAL_BITS - 2;
  localparam int PROD_W    = NORMAL_BITS + COORD_BITS;
  localparam int OFF_W     = COORD_BITS + FRAC_BITS;
  localparam int SUM_W     = PROD_W + 2;

  logic signed [NORMAL_BITS-1:0] nx1, ny1, nz1;
  logic signed [COORD_BITS-1:0]  vx1, vy1, vz1, off1;
  logic signed [PROD_W-1:0]      px2, py2, pz2;
  logic signed [OFF_W-1:0]       off2;
  logic signed [SUM_W-1:0]       sum;

  // positive vertex: max corner where the normal component is non-negative
  always_ff @(posedge clk) begin
    if (en.s1) begin
      nx1  <= nx;
      ny1  <= ny;
      nz1  <= nz;
      off1 <= off;
      vx1  <= nx[NORMAL_BITS-1] ? min_x : max_x;
      vy1  <= ny[NORMAL_BITS-1] ? min_y : max_y;
      vz1  <= nz[NORMAL_BITS-1] ? min_z : max_z;
    end
  end

  // offset lined up with the Q.14 products (FRAC_BITS fraction bits)
  always_ff @(posedge clk) begin
    if (en.s2) begin
      px2  <= nx1 * vx1;
      py2  <= ny1 * vy1;
      pz2  <= nz1 * vz1;
      off2 <= {off1, {FRAC_BITS{1'b0}}};
    end
  end

  assign sum = SUM_W'(px2) + SUM_W'(py2) + SUM_W'(pz2) + SUM_W'(off2);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      dist_neg <= sum[SUM_W-1];
    end
  end

endmodule

### rtl/aabb_frustum_cull_test.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test: AABB versus frustum, positive-vertex test
// Plane table plus a pipelined per-plane distance check.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tuser is the op (write plane / test box), s_tdata
//   carries plane index, normal, offset and box corners. A write transfer
//   stores one plane at once and gives no result; a later test sees it.
//   Output stream m_*: one transfer per test, m_tdata[0] = box_inside.
//   The result passes vertex select, products, sum and the reduce/output
//   register, in that order, and m_tvalid rises with it. Throughput: one
//   item per cycle while m_tready does not stall the output; all
//   NUM_PLANES planes are evaluated in parallel lanes.
//   Stall: each stage holds only while it is full and the next one is
//   blocked, so bubbles are squeezed out and input is still taken while a
//   result waits on m_tready, until all four stages are full. Nothing is
//   lost or repeated under stall.
//   Reset: clears the plane table to zero (zero planes never cull) and
//   empties the pipeline; items are accepted from the first cycle after.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test import afc_pkg::*; #(
  parameter int NUM_PLANES  = 6,
  parameter int COORD_BITS  = 32,
  parameter int NORMAL_BITS = 16,
  localparam int IN_END = PLANE_IDX_W + 3*NORMAL_BITS + 7*COORD_BITS,
  localparam int IN_W   = ((IN_END + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  // plane_index, normal_x, normal_y, normal_z, plane_offset,
  // min_x, min_y, min_z, max_x, max_y, max_z, zero fill
  input  logic [IN_W-1:0] s_tdata,
  input  logic            s_tuser,   // op
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [OUT_W-1:0] m_tdata   // box_inside, zero fill
);

  localparam int NX_LO   = PLANE_IDX_W;
  localparam int NY_LO   = NX_LO + NORMAL_BITS;
  localparam int NZ_LO   = NY_LO + NORMAL_BITS;
  localparam int OFF_LO  = NZ_LO + NORMAL_BITS;
  localparam int MINX_LO = OFF_LO + COORD_BITS;
  localparam int MINY_LO = MINX_LO + COORD_BITS;
  localparam int MINZ_LO = MINY_LO + COORD_BITS;
  localparam int MAXX_LO = MINZ_LO + COORD_BITS;
  localparam int MAXY_LO = MAXX_LO + COORD_BITS;
  localparam int MAXZ_LO = MAXY_LO + COORD_BITS;

  logic [PLANE_IDX_W-1:0]        plane_index;
  logic signed [NORMAL_BITS-1:0] normal_x, normal_y, normal_z;
  logic signed [COORD_BITS-1:0]  plane_offset;
  logic signed [COORD_BITS-1:0]  min_x, min_y, min_z, max_x, max_y, max_z;
  op_t                           op;

  assign op           = op_t'(s_tuser);
  assign plane_index  = s_tdata[PLANE_IDX_W-1:0];
  assign normal_x     = s_tdata[NX_LO +: NORMAL_BITS];
  assign normal_y     = s_tdata[NY_LO +: NORMAL_BITS];
  assign normal_z     = s_tdata[NZ_LO +: NORMAL_BITS];
  assign plane_offset = s_tdata[OFF_LO +: COORD_BITS];
  assign min_x        = s_tdata[MINX_LO +: COORD_BITS];
  assign min_y        = s_tdata[MINY_LO +: COORD_BITS];
  assign min_z        = s_tdata[MINZ_LO +: COORD_BITS];
  assign max_x        = s_tdata[MAXX_LO +: COORD_BITS];
  assign max_y        = s_tdata[MAXY_LO +: COORD_BITS];
  assign max_z        = s_tdata[MAXZ_LO +: COORD_BITS];

  logic          in_xfer, wr_en, test_en;
  logic          v1, v2, v3;
  logic          en_out;
  afc_stage_en_t en;

  // per-stage advance: a stage moves when empty or when the next one moves
  assign en_out   = !m_tvalid || m_tready;
  assign en.s3    = !v3 || en_out;
  assign en.s2    = !v2 || en.s3;
  assign en.s1    = !v1 || en.s2;
  assign s_tready = en.s1;

  assign in_xfer = s_tvalid && s_tready;
  assign wr_en   = in_xfer && (op == OP_WRITE);
  assign test_en = in_xfer && (op == OP_TEST);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en.s1) v1 <= test_en;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en_out) m_tvalid <= v3;
    end
  end

  logic signed [NORMAL_BITS-1:0] tab_nx  [NUM_PLANES];
  logic signed [NORMAL_BITS-1:0] tab_ny  [NUM_PLANES];
  logic signed [NORMAL_BITS-1:0] tab_nz  [NUM_PLANES];
  logic signed [COORD_BITS-1:0]  tab_off [NUM_PLANES];
  logic [NUM_PLANES-1:0]         dist_neg;

  afc_plane_table #(
    .NUM_PLANES (NUM_PLANES),
    .COORD_BITS (COORD_BITS),
    .NORMAL_BITS(NORMAL_BITS)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .wr_en (wr_en),
    .wr_idx(plane_index),
    .wr_nx (normal_x),
    .wr_ny (normal_y),
    .wr_nz (normal_z),
    .wr_off(plane_offset),
    .nx    (tab_nx),
    .ny    (tab_ny),
    .nz    (tab_nz),
    .off   (tab_off)
  );

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_plane
    afc_plane_eval #(
      .COORD_BITS (COORD_BITS),
      .NORMAL_BITS(NORMAL_BITS)
    ) u_eval (
      .clk     (clk),
      .en      (en),
      .nx      (tab_nx[i]),
      .ny      (tab_ny[i]),
      .nz      (tab_nz[i]),
      .off     (tab_off[i]),
      .min_x   (min_x),
      .min_y   (min_y),
      .min_z   (min_z),
      .max_x   (max_x),
      .max_y   (max_y),
      .max_z   (max_z),
      .dist_neg(dist_neg[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      m_tdata <= {{(OUT_W-1){1'b0}}, ~|dist_neg};
    end
  end

endmodule

### rtl/afc_checker.sv
// ----------------------------------------------------------------------------
// afc_checker: port-level checks for aabb_frustum_cull_test
// Output hold under stall, reset flush, latency in free flow, ready when idle.
// ----------------------------------------------------------------------------
module afc_checker import afc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // cycles since reset, saturating at the pipeline latency
  logic [2:0] since_rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      since_rst <= '0;
    end else if (since_rst != 3'd4) begin
      since_rst <= since_rst + 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed or dropped while stalled");

  a_rst_flush: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown right after reset");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // with the receiver ready, each accepted test and nothing else comes out once it has crossed the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    ((since_rst == 3'd4) && $past(m_tready, 1) && $past(m_tready, 2)
      && $past(m_tready, 3) && $past(m_tready, 4))
    |-> (m_tvalid == $past(s_tvalid && s_tready && (s_tuser == OP_TEST), 4)))
    else $error("result count or latency mismatch");

endmodule

bind aabb_frustum_cull_test afc_checker u_afc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
